[design/wshc_pkg.sv]
`timescale 1ns / 1ps

package wshc_pkg;

   localparam int BYTE_W      = 8;
   localparam int TALLY_W     = 16;
   localparam int LEN_W       = 5;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_INDEX_W = 2;

   localparam logic [BYTE_W-1:0]  SEPARATOR_BYTE = 8'h20;
   localparam logic [TALLY_W-1:0] TALLY_MAX      = 16'hFFFF;
   localparam logic [LEN_W-1:0]   LENGTH_RESET   = 5'd1;

   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LOW  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_HIGH = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LEN  = 2'd2;

   typedef struct packed {
      logic advance;
      logic flush;
   } wshc_ctl_type;

endpackage

[design/wshc_cell.sv]
`timescale 1ns / 1ps

module wshc_cell
   import wshc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  wshc_ctl_type      ctl,
   input  logic [BYTE_W-1:0] text_byte,
   input  logic [BYTE_W-1:0] pattern_byte,
   input  logic              cell_enable,
   input  logic              cell_last,
   input  logic              prev_match,
   output logic              match,
   output logic              hit
);

   logic match_ff;
   logic match_in;
   logic step_bit;

   assign step_bit = prev_match & cell_enable & (text_byte == pattern_byte);
   assign hit      = ctl.advance & ~ctl.flush & step_bit & cell_last;
   assign match    = match_ff;

   always_comb begin
      match_in = match_ff;
      if (ctl.advance) begin
         match_in = ctl.flush ? 1'b0 : step_bit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

endmodule

[design/wshc_tally.sv]
`timescale 1ns / 1ps

module wshc_tally
   import wshc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  wshc_ctl_type       ctl,
   input  logic               line_end,
   input  logic               hit,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output logic [TALLY_W-1:0] rsp_word_hits
);

   logic               word_hit_ff;
   logic               word_hit_in;
   logic [TALLY_W-1:0] tally_ff;
   logic [TALLY_W-1:0] tally_in;
   logic [TALLY_W-1:0] closed_tally;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [TALLY_W-1:0] rsp_hits_ff;
   logic [TALLY_W-1:0] rsp_hits_in;

   assign closed_tally = (word_hit_ff && tally_ff != TALLY_MAX) ?
                         tally_ff + TALLY_W'(1) : tally_ff;

   always_comb begin
      word_hit_in  = word_hit_ff;
      tally_in     = tally_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_hits_in  = rsp_hits_ff;
      if (ctl.advance) begin
         if (ctl.flush) begin
            word_hit_in = 1'b0;
            if (line_end) begin
               tally_in     = '0;
               rsp_valid_in = 1'b1;
               rsp_hits_in  = closed_tally;
            end else begin
               tally_in = closed_tally;
            end
         end else if (hit) begin
            word_hit_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_hit_ff  <= 1'b0;
         tally_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         word_hit_ff  <= word_hit_in;
         tally_ff     <= tally_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_hits_ff <= rsp_hits_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_word_hits = rsp_hits_ff;

endmodule

[design/word_substring_hit_counter.sv]
`timescale 1ns / 1ps

// Channel  Direction  Handshake          Payload
// req      in         req_valid/stall    req_text_byte[7:0], req_line_end
// rsp      out        rsp_valid/stall    rsp_word_hits[15:0]
// csr      in         csr_valid/ready    csr_index[1:0], csr_data[63:0]
//
// One request per cycle while req_stall is low; the prefix chain updates in the cycle of acceptance.
// A line-end request yields its count from the output register in the cycle after acceptance.
// Reset clears match state, tally, output valid and sets pattern length to one.
// Requests other than line end pass while a count waits on rsp_stall; a
// line-end request stalls only while the output register is still held.

module word_substring_hit_counter
   import wshc_pkg::*;
#(
   parameter int MAX_PATTERN = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [BYTE_W-1:0]      req_text_byte,
   input  logic                   req_line_end,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [TALLY_W-1:0]     rsp_word_hits,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   logic [CSR_DATA_W-1:0]   pattern_low_ff;
   logic [CSR_DATA_W-1:0]   pattern_high_ff;
   logic [LEN_W-1:0]        pattern_len_ff;
   logic [LEN_W-1:0]        len_used;
   logic [2*CSR_DATA_W-1:0] pattern_all;
   wshc_ctl_type            ctl;
   logic [MAX_PATTERN:0]    chain;
   logic [MAX_PATTERN-1:0]  cell_hit;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff  <= '0;
         pattern_high_ff <= '0;
         pattern_len_ff  <= LENGTH_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_PATTERN_LOW:  pattern_low_ff  <= csr_data;
            CSR_PATTERN_HIGH: pattern_high_ff <= csr_data;
            CSR_PATTERN_LEN:  pattern_len_ff  <= csr_data[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      len_used = pattern_len_ff;
      if (pattern_len_ff == '0) begin
         len_used = LEN_W'(1);
      end else if (pattern_len_ff > LEN_W'(MAX_PATTERN)) begin
         len_used = LEN_W'(MAX_PATTERN);
      end
   end

   assign pattern_all = {pattern_high_ff, pattern_low_ff};

   assign req_stall   = rsp_valid & rsp_stall & req_line_end;
   assign ctl.advance = req_valid & ~req_stall;
   assign ctl.flush   = req_line_end | (req_text_byte == SEPARATOR_BYTE);

   assign chain[0] = 1'b1;

   for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
      wshc_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctl          (ctl),
         .text_byte    (req_text_byte),
         .pattern_byte (pattern_all[j*BYTE_W +: BYTE_W]),
         .cell_enable  (LEN_W'(j) < len_used),
         .cell_last    (LEN_W'(j) == len_used - LEN_W'(1)),
         .prev_match   (chain[j]),
         .match        (chain[j+1]),
         .hit          (cell_hit[j])
      );
   end

   wshc_tally u_tally (
      .clock         (clock),
      .reset         (reset),
      .ctl           (ctl),
      .line_end      (req_line_end),
      .hit           (|cell_hit),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_word_hits (rsp_word_hits)
   );

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;
   import wshc_pkg::*;

   localparam int MAX_PATTERN    = 16;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES  = 4;
   localparam int PHASE_ITEMS    = 100;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [BYTE_W-1:0]      req_text_byte;
   logic                   req_line_end;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [TALLY_W-1:0]     rsp_word_hits;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   // shadow of the block
   logic [63:0]        cfg_low;
   logic [63:0]        cfg_high;
   logic [LEN_W-1:0]   cfg_len;
   logic [15:0]        prefix_bits;
   logic               word_hit;
   logic [TALLY_W-1:0] word_tally;

   logic [TALLY_W-1:0] hits_pending[$];
   logic [TALLY_W-1:0] hits_front;

   int error_count   = 0;
   int counts_seen   = 0;
   int items_sent    = 0;
   int lines_sent    = 0;
   int csr_writes    = 0;
   int idle_cycles   = 0;
   int stall_left    = 0;
   int stall_roll;
   bit idle_on       = 1'b0;
   bit stall_on      = 1'b0;

   word_substring_hit_counter u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_text_byte (req_text_byte),
      .req_line_end  (req_line_end),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_word_hits (rsp_word_hits),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int active_length();
      if (cfg_len == 0) return 1;
      if (cfg_len > MAX_PATTERN) return MAX_PATTERN;
      return int'(cfg_len);
   endfunction

   function automatic logic [BYTE_W-1:0] pattern_at(int j);
      if (j < 8) return cfg_low[8*j +: 8];
      return cfg_high[8*(j-8) +: 8];
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!idle_on || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [BYTE_W-1:0] text_char();
      if ($urandom_range(0, 9) < 7) return pattern_at($urandom_range(0, active_length() - 1));
      return BYTE_W'($urandom_range(0, 255));
   endfunction

   function automatic logic [63:0] pattern_word(bit allow_space);
      logic [63:0]       w;
      logic [BYTE_W-1:0] b;
      w = '0;
      for (int k = 0; k < 8; k++) begin
         if ($urandom_range(0, 3) < 3) b = 8'h61 + BYTE_W'($urandom_range(0, 3));
         else b = BYTE_W'($urandom_range(0, 255));
         if (!allow_space && b == SEPARATOR_BYTE) b = 8'h21;
         w[8*k +: 8] = b;
      end
      return w;
   endfunction

   task automatic report_mismatch(string what, logic [TALLY_W-1:0] want,
                                  logic [TALLY_W-1:0] got);
      $display("mismatch at %0t: %s, expected %0d, got %0d", $realtime, what, want, got);
      error_count++;
   endtask

   task automatic close_word();
      if (word_hit && word_tally != TALLY_MAX) word_tally = word_tally + 1'b1;
      word_hit    = 1'b0;
      prefix_bits = '0;
   endtask

   task automatic predict_item(logic [BYTE_W-1:0] text, logic line_end_flag);
      logic [15:0] mask;
      int          n;
      n = active_length();
      if (line_end_flag) begin
         close_word();
         hits_pending.push_back(word_tally);
         word_tally = '0;
      end else if (text == SEPARATOR_BYTE) begin
         close_word();
      end else begin
         mask = '0;
         for (int j = 0; j < n; j++)
            if (pattern_at(j) == text) mask[j] = 1'b1;
         prefix_bits = ((prefix_bits << 1) | 16'd1) & mask;
         if (prefix_bits[n-1]) word_hit = 1'b1;
      end
   endtask

   task automatic send_item(logic [BYTE_W-1:0] text, logic line_end_flag);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_text_byte <= text;
      req_line_end  <= line_end_flag;
      do @(posedge clock); while (!(req_valid && !req_stall));
      predict_item(text, line_end_flag);
      items_sent++;
      if (line_end_flag) lines_sent++;
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
   endtask

   task automatic wait_for_counts();
      req_valid <= 1'b0;
      while (hits_pending.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      case (idx)
         CSR_PATTERN_LOW:  cfg_low  = data;
         CSR_PATTERN_HIGH: cfg_high = data;
         CSR_PATTERN_LEN:  cfg_len  = data[LEN_W-1:0];
         default: ;
      endcase
      csr_writes++;
   endtask

   task automatic configure(logic [63:0] lo, logic [63:0] hi, logic [LEN_W-1:0] len);
      logic [CSR_DATA_W-1:0] len_word;
      wait_for_counts();
      repeat (SETTLE_CYCLES) @(posedge clock);
      len_word = {$urandom, $urandom};
      len_word[LEN_W-1:0] = len;
      write_csr(CSR_UNUSED, {$urandom, $urandom});
      write_csr(CSR_PATTERN_LOW, lo);
      write_csr(CSR_PATTERN_HIGH, hi);
      write_csr(CSR_PATTERN_LEN, len_word);
      csr_valid <= 1'b0;
   endtask

   task automatic send_line();
      int words;
      int n;
      n = active_length();
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(0, 20))
            send_item(($urandom_range(0, 7) == 0) ? SEPARATOR_BYTE :
                      BYTE_W'($urandom_range(0, 255)), 1'b0);
      end else begin
         words = $urandom_range(0, 6);
         for (int k = 0; k < words; k++) begin
            if (k > 0 || $urandom_range(0, 5) == 0)
               repeat (($urandom_range(0, 4) == 0) ? $urandom_range(2, 3) : 1)
                  send_item(SEPARATOR_BYTE, 1'b0);
            if ($urandom_range(0, 1) == 0) begin
               repeat ($urandom_range(0, 2)) send_item(text_char(), 1'b0);
               for (int j = 0; j < n; j++) send_item(pattern_at(j), 1'b0);
               repeat ($urandom_range(0, 2)) send_item(text_char(), 1'b0);
            end else begin
               repeat ($urandom_range(1, 6)) send_item(text_char(), 1'b0);
            end
         end
         if ($urandom_range(0, 5) == 0) send_item(SEPARATOR_BYTE, 1'b0);
      end
      send_item(BYTE_W'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic run_phase(logic [63:0] lo, logic [63:0] hi, logic [LEN_W-1:0] len,
                            bit idle, bit stall);
      int start;
      int lines;
      configure(lo, hi, len);
      idle_on  = idle;
      stall_on = stall;
      start    = items_sent;
      lines    = 0;
      while (items_sent - start < PHASE_ITEMS) begin
         send_line();
         lines++;
         if (lines % 9 == 0) wait_for_counts();
      end
   endtask

   task automatic test_defaults();
      idle_on  = 1'b1;
      stall_on = 1'b1;
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b1);
      send_item(SEPARATOR_BYTE, 1'b1);
   endtask

   task automatic test_pair_pattern();
      configure(64'h6261, 64'h0, 5'd2);
      send_text("ab  xab ba");
      send_item(8'h00, 1'b1);
   endtask

   task automatic test_space_in_pattern();
      configure(64'h6120, 64'h0, 5'd2);
      send_text("a a");
      send_item(8'h7F, 1'b1);
   endtask

   task automatic test_length_bounds();
      configure(64'hFF, 64'h0, 5'd0);
      send_item(8'hFF, 1'b0);
      send_item(8'h20, 1'b1);
      configure({8{8'h41}}, {8{8'h41}}, 5'd31);
      send_text("AAAAAAAAAAAAAAAA");
      send_item(8'h41, 1'b1);
   endtask

   task automatic test_random();
      run_phase(pattern_word(1'b0), pattern_word(1'b0), 5'd1, 1'b1, 1'b1);
      run_phase(pattern_word(1'b0), pattern_word(1'b0), 5'd16, 1'b0, 1'b0);
      run_phase({64{1'b1}}, {64{1'b1}}, 5'd31, 1'b1, 1'b1);
      run_phase(64'h0, 64'h0, 5'd0, 1'b1, 1'b1);
      repeat (4)
         run_phase(pattern_word($urandom_range(0, 3) == 0),
                   pattern_word($urandom_range(0, 3) == 0),
                   LEN_W'($urandom_range(0, 31)), 1'b1, 1'b1);
   endtask

   always @(posedge clock) begin
      if (!stall_on) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else begin
         stall_roll = $urandom_range(0, 99);
         if (stall_roll < 55) begin
            rsp_stall <= 1'b0;
         end else if (stall_roll < 92) begin
            rsp_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 2);
         end else begin
            rsp_stall  <= 1'b1;
            stall_left <= $urandom_range(10, 40);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (hits_pending.size() == 0) begin
            report_mismatch("count with none pending", '0, rsp_word_hits);
         end else begin
            hits_front = hits_pending.pop_front();
            if (rsp_word_hits !== hits_front)
               report_mismatch("word_hits", hits_front, rsp_word_hits);
         end
         counts_seen++;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   initial begin
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_text_byte <= '0;
      req_line_end  <= 1'b0;
      rsp_stall     <= 1'b0;
      csr_valid     <= 1'b0;
      csr_index     <= '0;
      csr_data      <= '0;
      cfg_low     = '0;
      cfg_high    = '0;
      cfg_len     = LENGTH_RESET;
      prefix_bits = '0;
      word_hit    = 1'b0;
      word_tally  = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_defaults();
      test_pair_pattern();
      test_space_in_pattern();
      test_length_bounds();
      test_random();

      wait_for_counts();
      repeat (2 * SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d requests in %0d lines, %0d counts checked, %0d register writes",
               items_sent, lines_sent, counts_seen, csr_writes);
      $display("patterns of length 0 to 31, spaces in pattern, output stalls, %0d errors",
               error_count);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

[word_substring_hit_counter.f]
design/wshc_pkg.sv
design/wshc_cell.sv
design/wshc_tally.sv
design/word_substring_hit_counter.sv
sim/tb.sv
